// ===== rtl/ntt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_pkg
// Shared constants, command codes and handshake types for the radix-2 NTT.
// ----------------------------------------------------------------------------
package ntt_pkg;

    localparam int VAL_W       = 30;
    localparam int IDX_W       = 10;
    localparam int FUNC_W      = 2;
    localparam int LS_W        = 5;
    localparam int CFG_W       = 4;
    localparam int LOG_MAX_DEF = 10;
    // Exponent of the largest power of two dividing the modulus minus one
    localparam int TOP_EXP     = 23;

    localparam logic [VAL_W-1:0] MODULUS = 30'd998244353;

    // Command codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_LOG_SIZE = 1'b0;
    localparam logic CFG_INVERSE  = 1'b1;

    // Primitive 2^23-th root of unity, 3^119 mod p, and its inverse
    localparam logic [VAL_W-1:0] ROOT_FWD = 30'd15311432;
    localparam logic [VAL_W-1:0] ROOT_INV = 30'd469870224;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] result;
    } mul_rsp_t;

endpackage

// ===== rtl/ntt_mulmod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_mulmod
// Bit-serial modular multiplier: one bit of b per cycle, MSB first.
// ----------------------------------------------------------------------------
module ntt_mulmod
(
    input  logic              clk,
    input  logic              rst_n,
    input  ntt_pkg::mul_req_t req,
    output ntt_pkg::mul_rsp_t rsp
);

    localparam int VW = ntt_pkg::VAL_W;
    localparam logic [VW+1:0] MOD_X = {2'b00, ntt_pkg::MODULUS};
    localparam logic [4:0] LAST = 5'(VW - 1);

    logic [VW-1:0] acc_reg, acc_next;
    logic [VW-1:0] a_reg, a_next;
    logic [VW-1:0] b_reg, b_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW+1:0] dbl, s1, s2;

    // One step: acc = 2*acc + bit*a, reduced by up to two subtracts
    always_comb
    begin
        dbl = {1'b0, acc_reg, 1'b0} + (b_reg[VW-1] ? {2'b00, a_reg} : '0);
        s1  = (dbl >= MOD_X) ? dbl - MOD_X : dbl;
        s2  = (s1 >= MOD_X) ? s1 - MOD_X : s1;
    end

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next  = '0;
            a_next    = req.a;
            b_next    = req.b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = s2[VW-1:0];
            b_next   = {b_reg[VW-2:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

`ifndef ASSERT_OFF
    // Result is fully reduced when presented
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (acc_reg < ntt_pkg::MODULUS))
        else $error("mulmod result not reduced");
    // Done comes only at the end of a run
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("mulmod done without run");
    // A start is never issued while a product is in flight
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start)
        else $error("mulmod restarted while busy");
`endif

endmodule

// ===== rtl/ntt_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_store
// Coefficient memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ntt_store
#(
    parameter int AW = ntt_pkg::LOG_MAX_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [ntt_pkg::VAL_W-1:0] wdata,
    input  logic [AW-1:0]            raddr,
    output logic [ntt_pkg::VAL_W-1:0] rdata
);

    logic [ntt_pkg::VAL_W-1:0] mem [0:(1 << AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/number_theoretic_transform_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_theoretic_transform_top
// Radix-2 NTT mod 998244353: store, bit-reverse, butterflies, inverse 1/N scaling.
// ----------------------------------------------------------------------------
// A read goes via the store's registered data to the output register, waiting
// while the output stalls. Run on N = 2^log_size points: bit reversal, then per
// stage root squarings, butterflies and twiddle steps, all products bit-serial;
// inverse adds 1/N scaling. One command at a time, in_stall high until it ends.
// Reset clears control state and configuration (log_size 10, forward);
// store contents are undefined until written.
// ----------------------------------------------------------------------------
module number_theoretic_transform_top
#(
    parameter int LOG_MAX = ntt_pkg::LOG_MAX_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [ntt_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [ntt_pkg::FUNC_W-1:0] func,
    input  logic [ntt_pkg::IDX_W-1:0]  index,
    input  logic [ntt_pkg::VAL_W-1:0]  coeff,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [ntt_pkg::VAL_W-1:0]  value,
    output logic [ntt_pkg::IDX_W-1:0]  out_index
);

    localparam int AW = LOG_MAX;
    localparam int VW = ntt_pkg::VAL_W;
    localparam int IW = ntt_pkg::IDX_W;
    localparam int LW = ntt_pkg::LS_W;
    localparam logic [VW-1:0] MOD = ntt_pkg::MODULUS;
    localparam logic [LW-1:0] LS_MAX = LW'(LOG_MAX);
    localparam logic [LW-1:0] TOP = LW'(ntt_pkg::TOP_EXP);

    // Sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RDW   = 5'd1;
    localparam logic [4:0] S_BR_A  = 5'd2;
    localparam logic [4:0] S_BR_B  = 5'd3;
    localparam logic [4:0] S_BR_C  = 5'd4;
    localparam logic [4:0] S_BR_D  = 5'd5;
    localparam logic [4:0] S_ST    = 5'd6;
    localparam logic [4:0] S_SQ    = 5'd7;
    localparam logic [4:0] S_SQ2   = 5'd8;
    localparam logic [4:0] S_BF_A  = 5'd9;
    localparam logic [4:0] S_BF_B  = 5'd10;
    localparam logic [4:0] S_BF_C  = 5'd11;
    localparam logic [4:0] S_BF_W1 = 5'd12;
    localparam logic [4:0] S_BF_W2 = 5'd13;
    localparam logic [4:0] S_TW    = 5'd14;
    localparam logic [4:0] S_SC_A  = 5'd15;
    localparam logic [4:0] S_SC_B  = 5'd16;
    localparam logic [4:0] S_SC_W  = 5'd17;
    localparam logic [4:0] S_MULW  = 5'd18;

    logic [4:0]    state_reg, state_next;
    logic [4:0]    ret_reg, ret_next;
    logic [3:0]    log_size_reg;
    logic          inverse_reg;
    logic [LW-1:0] ls_reg, ls_next;
    logic [LW-1:0] s_reg, s_next;
    logic [LW-1:0] sqc_reg, sqc_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW:0]   j_reg, j_next;
    logic [AW:0]   r_reg, r_next;
    logic [VW-1:0] w_reg, w_next;
    logic [VW-1:0] tw_reg, tw_next;
    logic [VW-1:0] x_reg, x_next;
    logic [VW-1:0] val_reg, val_next;
    logic [IW-1:0] oidx_reg, oidx_next;
    logic          ov_reg, ov_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [VW-1:0] mem_wdata, mem_q;
    ntt_pkg::mul_req_t mreq;
    ntt_pkg::mul_rsp_t mrsp;

    logic [AW-1:0] pos;
    logic [AW:0]   sz, half, span;
    logic [AW-1:0] rev_full, rev;
    logic [AW-1:0] addr_a, addr_b;
    logic [VW:0]   sum, diff;
    logic [VW-1:0] sum_mod, diff_mod, coeff_mod, scale;
    logic [LW-1:0] ls_sat;
    logic          accept;

    // Index wrap to the store size
    generate
        if (AW <= IW)
        begin : g_pos_narrow
            assign pos = index[AW-1:0];
        end
        else
        begin : g_pos_wide
            assign pos = {{(AW-IW){1'b0}}, index};
        end
    endgenerate

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign ls_sat = ({1'b0, log_size_reg} > LS_MAX) ? LS_MAX : {1'b0, log_size_reg};

    // Transform geometry
    assign sz   = (AW+1)'(1) << ls_reg;
    assign half = (AW+1)'(1) << (s_reg - LW'(1));
    assign span = (AW+1)'(1) << s_reg;

    // Bit reversal over ls bits
    always_comb
    begin
        for (int b = 0; b < AW; b++)
        begin
            rev_full[b] = i_reg[AW-1-b];
        end
    end
    assign rev = rev_full >> (LW'(AW) - ls_reg);

    assign addr_a = AW'(j_reg + r_reg);
    assign addr_b = AW'(j_reg + r_reg + half);

    // Butterfly add/subtract mod p
    assign sum      = {1'b0, x_reg} + {1'b0, mrsp.result};
    assign sum_mod  = (sum >= {1'b0, MOD}) ? VW'(sum - {1'b0, MOD}) : VW'(sum);
    assign diff     = {1'b0, x_reg} + {1'b0, MOD} - {1'b0, mrsp.result};
    assign diff_mod = (diff >= {1'b0, MOD}) ? VW'(diff - {1'b0, MOD}) : VW'(diff);
    assign coeff_mod = (coeff >= MOD) ? coeff - MOD : coeff;

    // Inverse of 2^ls: p - (p-1)/2^ls
    assign scale = MOD - ((MOD - VW'(1)) >> ls_reg);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        ls_next    = ls_reg;
        s_next     = s_reg;
        sqc_next   = sqc_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        r_next     = r_reg;
        w_next     = w_reg;
        tw_next    = tw_reg;
        x_next     = x_reg;
        val_next   = val_reg;
        oidx_next  = oidx_reg;
        ov_next    = ov_reg && out_stall;
        mem_we     = 1'b0;
        mem_waddr  = i_reg;
        mem_wdata  = mem_q;
        mem_raddr  = i_reg;
        mreq.start = 1'b0;
        mreq.a     = mem_q;
        mreq.b     = tw_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        ntt_pkg::FUNC_WRITE:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pos;
                            mem_wdata = coeff_mod;
                        end
                        ntt_pkg::FUNC_RUN:
                        begin
                            ls_next    = ls_sat;
                            i_next     = '0;
                            state_next = S_BR_A;
                        end
                        ntt_pkg::FUNC_READ:
                        begin
                            // Address held in i_reg so the read stays put while waiting
                            mem_raddr  = pos;
                            i_next     = pos;
                            state_next = S_RDW;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RDW:
            begin
                if (!ov_reg || !out_stall)
                begin
                    val_next   = mem_q;
                    oidx_next  = IW'(i_reg);
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            // Bit-reversal permutation
            S_BR_A:
            begin
                if (i_reg < rev)
                begin
                    state_next = S_BR_B;
                end
                else if ({1'b0, i_reg} == sz - (AW+1)'(1))
                begin
                    s_next     = LW'(1);
                    state_next = S_ST;
                end
                else
                begin
                    i_next = i_reg + AW'(1);
                end
            end
            S_BR_B:
            begin
                x_next     = mem_q;
                mem_raddr  = rev;
                state_next = S_BR_C;
            end
            S_BR_C:
            begin
                mem_we     = 1'b1;
                mem_waddr  = i_reg;
                mem_wdata  = mem_q;
                state_next = S_BR_D;
            end
            S_BR_D:
            begin
                mem_we    = 1'b1;
                mem_waddr = rev;
                mem_wdata = x_reg;
                if ({1'b0, i_reg} == sz - (AW+1)'(1))
                begin
                    s_next     = LW'(1);
                    state_next = S_ST;
                end
                else
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = S_BR_A;
                end
            end
            // Stage setup: root for this stage by repeated squaring
            S_ST:
            begin
                if (s_reg > ls_reg)
                begin
                    i_next     = '0;
                    state_next = inverse_reg ? S_SC_A : S_IDLE;
                end
                else
                begin
                    w_next     = inverse_reg ? ntt_pkg::ROOT_INV : ntt_pkg::ROOT_FWD;
                    sqc_next   = TOP - s_reg;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                if (sqc_reg == '0)
                begin
                    tw_next    = VW'(1);
                    r_next     = '0;
                    j_next     = '0;
                    state_next = S_BF_A;
                end
                else
                begin
                    mreq.start = 1'b1;
                    mreq.a     = w_reg;
                    mreq.b     = w_reg;
                    ret_next   = S_SQ2;
                    state_next = S_MULW;
                end
            end
            S_SQ2:
            begin
                w_next     = mrsp.result;
                sqc_next   = sqc_reg - LW'(1);
                state_next = S_SQ;
            end
            // Butterfly
            S_BF_A:
            begin
                mem_raddr  = addr_a;
                state_next = S_BF_B;
            end
            S_BF_B:
            begin
                x_next     = mem_q;
                mem_raddr  = addr_b;
                state_next = S_BF_C;
            end
            S_BF_C:
            begin
                mreq.start = 1'b1;
                mreq.a     = mem_q;
                mreq.b     = tw_reg;
                ret_next   = S_BF_W1;
                state_next = S_MULW;
            end
            S_BF_W1:
            begin
                mem_we     = 1'b1;
                mem_waddr  = addr_a;
                mem_wdata  = sum_mod;
                state_next = S_BF_W2;
            end
            S_BF_W2:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_b;
                mem_wdata = diff_mod;
                if (j_reg + span >= sz)
                begin
                    j_next = '0;
                    if (r_reg == half - (AW+1)'(1))
                    begin
                        s_next     = s_reg + LW'(1);
                        state_next = S_ST;
                    end
                    else
                    begin
                        mreq.start = 1'b1;
                        mreq.a     = tw_reg;
                        mreq.b     = w_reg;
                        ret_next   = S_TW;
                        state_next = S_MULW;
                    end
                end
                else
                begin
                    j_next     = j_reg + span;
                    state_next = S_BF_A;
                end
            end
            S_TW:
            begin
                tw_next    = mrsp.result;
                r_next     = r_reg + (AW+1)'(1);
                state_next = S_BF_A;
            end
            // Inverse scaling
            S_SC_A:
            begin
                state_next = S_SC_B;
            end
            S_SC_B:
            begin
                mreq.start = 1'b1;
                mreq.a     = mem_q;
                mreq.b     = scale;
                ret_next   = S_SC_W;
                state_next = S_MULW;
            end
            S_SC_W:
            begin
                mem_we    = 1'b1;
                mem_waddr = i_reg;
                mem_wdata = mrsp.result;
                if ({1'b0, i_reg} == sz - (AW+1)'(1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = S_SC_A;
                end
            end
            S_MULW:
            begin
                if (mrsp.done)
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            ov_reg       <= 1'b0;
            log_size_reg <= 4'd10;
            inverse_reg  <= 1'b0;
            ls_reg       <= '0;
            s_reg        <= '0;
            sqc_reg      <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            r_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            ov_reg    <= ov_next;
            ls_reg    <= ls_next;
            s_reg     <= s_next;
            sqc_reg   <= sqc_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            r_reg     <= r_next;
            if (cfg_we)
            begin
                if (cfg_index == ntt_pkg::CFG_LOG_SIZE)
                begin
                    log_size_reg <= cfg_data;
                end
                else
                begin
                    inverse_reg <= cfg_data[0];
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        tw_reg   <= tw_next;
        x_reg    <= x_next;
        val_reg  <= val_next;
        oidx_reg <= oidx_next;
    end

    ntt_store #(.AW(AW)) u_store
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    ntt_mulmod u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    assign out_valid = ov_reg;
    assign value     = val_reg;
    assign out_index = oidx_reg;

`ifndef ASSERT_OFF
    // A new result beat is loaded only from the read wait state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg) == S_RDW)
        else $error("result beat from wrong state");
    // Multiplier finishes only while the sequencer waits for it
    a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mrsp.done |-> state_reg == S_MULW)
        else $error("product arrived while not waiting");
    // Butterflies run only within a valid stage
    a_stage: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BF_A |-> (s_reg != '0) && (s_reg <= ls_reg))
        else $error("butterfly outside stage range");
    // Transform length never exceeds the store
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> ls_reg <= LS_MAX)
        else $error("length beyond store");
`endif

endmodule

// ===== dv/number_theoretic_transform_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_theoretic_transform_top_tb
// Self-checking bench for the radix-2 NTT: a queue-fed driver sends write,
// run and read beats, an internal transform predicts every read, and a
// monitor checks each returned value and index under random idling.
// ----------------------------------------------------------------------------
module number_theoretic_transform_top_tb;

    localparam longint unsigned PRIME = 64'd998244353;
    localparam int STORE_DEPTH = 1024;
    localparam int FILL_DEPTH = 512;
    localparam int LIMIT = 4000000;
    localparam logic [ntt_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;

    typedef struct {
        logic [ntt_pkg::FUNC_W-1:0] op;
        logic [ntt_pkg::IDX_W-1:0]  pos;
        logic [ntt_pkg::VAL_W-1:0]  val;
    } command_t;

    typedef struct {
        logic [ntt_pkg::VAL_W-1:0] val;
        logic [ntt_pkg::IDX_W-1:0] pos;
    } readback_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic                        cfg_index;
    logic [ntt_pkg::CFG_W-1:0]   cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic [ntt_pkg::FUNC_W-1:0]  func;
    logic [ntt_pkg::IDX_W-1:0]   index;
    logic [ntt_pkg::VAL_W-1:0]   coeff;
    logic                        out_valid;
    logic                        out_stall;
    logic [ntt_pkg::VAL_W-1:0]   value;
    logic [ntt_pkg::IDX_W-1:0]   out_index;

    command_t        pending_cmds[$];
    readback_t       expected_reads[$];
    command_t        offered;
    longint unsigned coef_store[STORE_DEPTH];
    longint unsigned twiddle[STORE_DEPTH + 1];
    int              pred_log;
    bit              pred_inv;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              errors;
    int              reads_checked;
    int              runs_done;
    int              cycles;
    bit              hold_go;
    bit              hold_done;
    int              hold_left;

    number_theoretic_transform_top DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .index(index), .coeff(coeff),
        .out_valid(out_valid), .out_stall(out_stall),
        .value(value), .out_index(out_index)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b);
        return (a * b) % PRIME;
    endfunction

    function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e);
        longint unsigned acc;
        acc = 1;
        b = b % PRIME;
        while (e != 0)
        begin
            if (e[0])
                acc = mul_mod(acc, b);
            b = mul_mod(b, b);
            e = e >> 1;
        end
        return acc;
    endfunction

    // In-place transform of the predicted store: bit reverse, butterflies, then 1/N if inverse
    task automatic transform_store();
        int ls, sz, rev, half, e;
        longint unsigned u, v, t, scale;
        ls = (pred_log > 10) ? 10 : pred_log;
        sz = 1 << ls;
        for (int i = 0; i < sz; i++)
        begin
            rev = 0;
            for (int b = 0; b < ls; b++)
                rev = (rev << 1) | ((i >> b) & 1);
            if (i < rev)
            begin
                t = coef_store[i];
                coef_store[i] = coef_store[rev];
                coef_store[rev] = t;
            end
        end
        for (int s = 1; s <= ls; s++)
        begin
            half = 1 << (s - 1);
            for (int j = 0; j < sz; j += 2 * half)
                for (int r = 0; r < half; r++)
                begin
                    e = r << (10 - s);
                    if (pred_inv)
                        e = STORE_DEPTH - e;
                    u = coef_store[j + r];
                    v = mul_mod(coef_store[j + r + half], twiddle[e]);
                    coef_store[j + r] = (u + v) % PRIME;
                    coef_store[j + r + half] = (u + PRIME - v) % PRIME;
                end
        end
        if (pred_inv)
        begin
            scale = pow_mod(sz, PRIME - 2);
            for (int i = 0; i < sz; i++)
                coef_store[i] = mul_mod(coef_store[i], scale);
        end
    endtask

    // Predicted effect of one accepted command beat
    task automatic predict_command(command_t c);
        readback_t rb;
        case (c.op)
            ntt_pkg::FUNC_WRITE: coef_store[c.pos] = longint'(c.val) % PRIME;
            ntt_pkg::FUNC_RUN:
            begin
                transform_store();
                runs_done++;
            end
            ntt_pkg::FUNC_READ:
            begin
                rb.val = ntt_pkg::VAL_W'(coef_store[c.pos]);
                rb.pos = c.pos;
                expected_reads.push_back(rb);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func     <= FUNC_NONE;
            index    <= '0;
            coeff    <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_command(offered);
            if (!in_valid || !in_stall)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    func     <= offered.op;
                    index    <= offered.pos;
                    coeff    <= offered.val;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, with one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_left <= 400;
            hold_done <= 1'b1;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reads.size() == 0)
                report_mismatch("unexpected beat, index", out_index, 0);
            else
            begin
                readback_t want;
                want = expected_reads.pop_front();
                if (value !== want.val)
                    report_mismatch("value", value, want.val);
                if (out_index !== want.pos)
                    report_mismatch("out_index", out_index, want.pos);
                reads_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_cmd(logic [ntt_pkg::FUNC_W-1:0] op, int pos,
                            logic [ntt_pkg::VAL_W-1:0] val);
        command_t c;
        c.op  = op;
        c.pos = ntt_pkg::IDX_W'(pos);
        c.val = val;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || in_valid || in_stall || expected_reads.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_config(logic idx, logic [ntt_pkg::CFG_W-1:0] d);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == ntt_pkg::CFG_LOG_SIZE)
            pred_log = d;
        else
            pred_inv = d[0];
    endtask

    // Idle pattern by phase: none, sender, receiver, both
    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 71; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 71; end
            default: begin send_idle_pct = 30; recv_idle_pct = 30; end
        endcase
    endtask

    function automatic logic [ntt_pkg::VAL_W-1:0] random_coeff();
        if ($urandom_range(3) == 0)
            return ntt_pkg::VAL_W'($urandom);
        return ntt_pkg::VAL_W'($urandom_range(998244352));
    endfunction

    // Random mix within a size; reads and runs stay inside the filled range
    task automatic random_phase(int ls, int count);
        int sz, pick, pos;
        sz = 1 << ((ls > 10) ? 10 : ls);
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if ($urandom_range(3) != 0)
                pos = $urandom_range(sz - 1);
            else if (pick < 40)
                pos = $urandom_range(STORE_DEPTH - 1);
            else
                pos = $urandom_range(FILL_DEPTH - 1);
            if (pick < 40)
                push_cmd(ntt_pkg::FUNC_WRITE, pos, random_coeff());
            else if (pick < 85)
                push_cmd(ntt_pkg::FUNC_READ, pos, random_coeff());
            else if (pick < 93)
                push_cmd(ntt_pkg::FUNC_RUN, pos, random_coeff());
            else
                push_cmd(FUNC_NONE, pos, random_coeff());
        end
    endtask

    initial
    begin
        int sizes[8];
        sizes = '{1, 2, 3, 4, 5, 6, 0, 3};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ntt_pkg::CFG_LOG_SIZE;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        errors = 0;
        reads_checked = 0;
        runs_done = 0;
        cycles = 0;
        hold_go = 1'b0;
        pred_log = 10;
        pred_inv = 1'b0;
        twiddle[0] = 1;
        for (int i = 1; i <= STORE_DEPTH; i++)
            twiddle[i] = mul_mod(twiddle[i - 1], pow_mod(3, (PRIME - 1) >> 10));
        for (int i = 0; i < STORE_DEPTH; i++)
            coef_store[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: length one, coefficient extremes, unused command
        write_config(ntt_pkg::CFG_LOG_SIZE, 4'd0);
        write_config(ntt_pkg::CFG_INVERSE, 4'd0);
        push_cmd(ntt_pkg::FUNC_WRITE, 0, 30'd998244352);
        push_cmd(FUNC_NONE, 0, 30'd0);
        push_cmd(ntt_pkg::FUNC_RUN, 0, 30'd0);
        push_cmd(ntt_pkg::FUNC_READ, 0, 30'd0);
        push_cmd(ntt_pkg::FUNC_WRITE, 1023, 30'h3FFFFFFF);
        push_cmd(ntt_pkg::FUNC_WRITE, 512, 30'd998244353);
        push_cmd(ntt_pkg::FUNC_WRITE, 1, 30'd0);
        push_cmd(ntt_pkg::FUNC_READ, 1023, 30'd0);
        push_cmd(ntt_pkg::FUNC_READ, 512, 30'd0);
        push_cmd(ntt_pkg::FUNC_READ, 1, 30'd0);
        push_cmd(FUNC_NONE, 1023, 30'h3FFFFFFF);
        wait_idle();
        write_config(ntt_pkg::CFG_INVERSE, 4'b1111);
        push_cmd(ntt_pkg::FUNC_RUN, 0, 30'd0);
        push_cmd(ntt_pkg::FUNC_READ, 0, 30'd0);
        wait_idle();

        // Fill the lower half, then a 512-point forward transform
        write_config(ntt_pkg::CFG_LOG_SIZE, 4'd9);
        write_config(ntt_pkg::CFG_INVERSE, 4'd0);
        set_idling(1);
        for (int i = 0; i < FILL_DEPTH; i++)
            push_cmd(ntt_pkg::FUNC_WRITE, i, random_coeff());
        push_cmd(ntt_pkg::FUNC_RUN, 0, 30'd0);
        for (int k = 0; k < 24; k++)
            push_cmd(ntt_pkg::FUNC_READ, $urandom_range(FILL_DEPTH - 1), 30'd0);
        wait_idle();

        // Inverse of the same size with a long receiver hold-off
        write_config(ntt_pkg::CFG_INVERSE, 4'd1);
        set_idling(0);
        push_cmd(ntt_pkg::FUNC_RUN, 0, 30'd0);
        for (int k = 0; k < 40; k++)
            push_cmd(ntt_pkg::FUNC_READ, $urandom_range(FILL_DEPTH - 1), 30'd0);
        while (in_stall || pending_cmds.size() > 36)
            @(posedge clk);
        hold_go = 1'b1;
        wait_idle();
        hold_go = 1'b0;

        // Random phases over small sizes, both directions
        for (int p = 0; p < 8; p++)
        begin
            write_config(ntt_pkg::CFG_LOG_SIZE, ntt_pkg::CFG_W'(sizes[p]));
            write_config(ntt_pkg::CFG_INVERSE, ntt_pkg::CFG_W'(p % 2));
            set_idling(p);
            random_phase(sizes[p], 40);
            wait_idle();
        end

        $display("covered %0d transform runs and %0d checked reads, sizes 1 to 512,",
                 runs_done, reads_checked);
        $display("forward and inverse, oversized coefficients, all idle modes");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
